/* rtl/ppm_pkg.sv */
// Shared types and constants for the plain-text colour image token parser.
// No dependencies; imported by ppm_step and ascii_ppm_token_parser.
package ppm_pkg;

    // widest header number that is still in range
    localparam int HEADER_VALUE_BITS = 16;

    localparam logic [63:0] HDR_LIMIT_RAW = (64'd1 << HEADER_VALUE_BITS) - 64'd1;
    localparam logic [16:0] HDR_LIMIT = (HEADER_VALUE_BITS >= 16) ? 17'd65535
                                                                  : HDR_LIMIT_RAW[16:0];

    // accumulator saturation point and sample range
    localparam logic [16:0] ACC_SAT    = 17'd65536;
    localparam logic [16:0] VALUE_MAX  = 17'd65535;
    localparam logic [16:0] SAMPLE_MAX = 17'd255;

    // characters of interest
    localparam logic [7:0] CH_ZERO = 8'd48;
    localparam logic [7:0] CH_NINE = 8'd57;
    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_3    = 8'h33;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;

    // result kinds
    localparam logic [1:0] KIND_WIDTH  = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd3;

    // result error codes
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SAMPLE = 2'd1;
    localparam logic [1:0] ERR_HEADER = 2'd2;
    localparam logic [1:0] ERR_MAGIC  = 2'd3;

    // channel codes
    localparam logic [1:0] CHAN_RED  = 2'd0;
    localparam logic [1:0] CHAN_BLUE = 2'd2;

    // last header slot
    localparam logic [1:0] HDR_LAST = 2'd2;

    typedef enum logic [1:0] {
        PH_MAGIC  = 2'd0,
        PH_FORMAT = 2'd1,
        PH_HEADER = 2'd2,
        PH_BODY   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        LX_SPACE   = 2'd0,
        LX_NUMBER  = 2'd1,
        LX_COMMENT = 2'd2
    } t_lex;

    typedef struct packed {
        t_phase      phase;
        t_lex        lex;
        logic [16:0] acc;
        logic [1:0]  hdr_idx;
        logic [1:0]  chan;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:   PH_MAGIC,
        lex:     LX_SPACE,
        acc:     17'd0,
        hdr_idx: 2'd0,
        chan:    CHAN_RED
    };

    typedef struct packed {
        logic        valid;
        logic [15:0] value;
        logic [1:0]  kind;
        logic [1:0]  channel;
        logic [1:0]  error;
    } t_result;

endpackage

/* rtl/ppm_step.sv */
// Per-character parser step: next state and optional result from one item.
// Depends on ppm_pkg.
module ppm_step (
    input  logic [7:0]      i_char,
    input  logic            i_eod,
    input  ppm_pkg::t_state i_state,
    output ppm_pkg::t_state o_state,
    output ppm_pkg::t_result o_result
);
    import ppm_pkg::*;

    logic        digit;
    logic [3:0]  digit_val;
    logic [19:0] acc_x10;
    logic        end_token;
    logic        do_finish;
    t_state      nx;
    t_result     res;

    assign digit     = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign digit_val = 4'(i_char - CH_ZERO);
    // acc * 10 + digit as shift-add
    assign acc_x10   = {i_state.acc, 3'b000} + {2'b00, i_state.acc, 1'b0}
                     + {16'd0, digit_val};

    always_comb begin
        nx        = i_state;
        res       = '0;
        end_token = 1'b0;
        do_finish = 1'b0;

        // magic check and lexer
        unique case (i_state.phase)
            PH_MAGIC: begin
                if (i_char == CH_P) begin
                    nx.phase = PH_FORMAT;
                end else begin
                    res.valid = 1'b1;
                    res.error = ERR_MAGIC;
                end
            end
            PH_FORMAT: begin
                if (i_char == CH_3) begin
                    nx.phase = PH_HEADER;
                    nx.lex   = LX_SPACE;
                    nx.acc   = '0;
                end else begin
                    nx.phase  = PH_MAGIC;
                    res.valid = 1'b1;
                    res.error = ERR_MAGIC;
                end
            end
            default: begin
                unique case (i_state.lex)
                    LX_COMMENT: begin
                        if (i_char == CH_LF) begin
                            nx.lex = LX_SPACE;
                        end
                    end
                    LX_NUMBER: begin
                        if (digit) begin
                            nx.acc = (acc_x10 > {3'b000, ACC_SAT}) ? ACC_SAT
                                                                   : acc_x10[16:0];
                        end else begin
                            end_token = 1'b1;
                            nx.lex    = (i_char == CH_HASH) ? LX_COMMENT : LX_SPACE;
                        end
                    end
                    default: begin
                        if (digit) begin
                            nx.acc = {13'd0, digit_val};
                            nx.lex = LX_NUMBER;
                        end else if (i_char == CH_HASH) begin
                            nx.lex = LX_COMMENT;
                        end
                    end
                endcase
            end
        endcase

        // a token ends on a separator, or is flushed at end of data
        do_finish = end_token
                  || (i_eod && !res.valid && (nx.lex == LX_NUMBER)
                      && ((nx.phase == PH_HEADER) || (nx.phase == PH_BODY)));

        if (do_finish) begin
            res.valid = 1'b1;
            res.value = (nx.acc > VALUE_MAX) ? VALUE_MAX[15:0] : nx.acc[15:0];
            if (nx.phase == PH_HEADER) begin
                res.kind    = nx.hdr_idx;
                res.channel = CHAN_RED;
                res.error   = (nx.acc > HDR_LIMIT) ? ERR_HEADER : ERR_NONE;
                if (nx.hdr_idx >= HDR_LAST) begin
                    nx.hdr_idx = '0;
                    nx.phase   = PH_BODY;
                end else begin
                    nx.hdr_idx = nx.hdr_idx + 2'd1;
                end
            end else begin
                res.kind    = KIND_SAMPLE;
                res.channel = nx.chan;
                if (nx.acc > SAMPLE_MAX) begin
                    // over-range sample is dropped, channel holds
                    res.error = ERR_SAMPLE;
                end else begin
                    res.error = ERR_NONE;
                    nx.chan   = (nx.chan >= CHAN_BLUE) ? CHAN_RED : nx.chan + 2'd1;
                end
            end
            nx.acc = '0;
        end

        // end of data returns to the start of an image
        if (i_eod) begin
            nx = STATE_RESET;
        end

        o_state  = nx;
        o_result = res;
    end

endmodule

/* rtl/ascii_ppm_token_parser.sv */
// Top level of the plain-text colour image token parser: input register,
// parser state, result register. Depends on ppm_pkg and ppm_step.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  input   | in        | i_valid / o_stall  | i_char_in, i_end_of_data
//  result  | out       | o_valid / i_stall  | o_value, o_kind, o_channel, o_error
//
// One character per cycle sustained while the receiver does not stall; each item passes
// the input register, then the parser step into the result register. The parser state
// loops back through the combinational step, which sets the one-item-per-cycle rate.
// Synchronous active-low reset clears the valid flags and the parser state.
// A stalled result holds; the input stalls only while the input register holds an
// item and the result register holds a stalled result.
module ascii_ppm_token_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_value,
    output logic [1:0]  o_kind,
    output logic [1:0]  o_channel,
    output logic [1:0]  o_error
);
    import ppm_pkg::*;

    logic        r_in_valid, n_in_valid;
    logic [7:0]  r_char;
    logic        r_eod;
    t_state      r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_value;
    logic [1:0]  r_kind;
    logic [1:0]  r_channel;
    logic [1:0]  r_error;

    logic        in_take;
    logic        fire;
    t_state      step_state;
    t_result     step_res;

    // handshake control
    assign fire    = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall = r_in_valid && !fire;
    assign in_take = i_valid && !o_stall;

    assign n_in_valid  = in_take ? 1'b1 : (fire ? 1'b0 : r_in_valid);
    assign n_out_valid = fire ? step_res.valid : (r_out_valid && i_stall);
    assign n_state     = fire ? step_state : r_state;

    ppm_step u_step (
        .i_char   (r_char),
        .i_eod    (r_eod),
        .i_state  (r_state),
        .o_state  (step_state),
        .o_result (step_res)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
        end
    end

    // input item register
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char <= i_char_in;
            r_eod  <= i_end_of_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (fire && step_res.valid) begin
            r_value   <= step_res.value;
            r_kind    <= step_res.kind;
            r_channel <= step_res.channel;
            r_error   <= step_res.error;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_value   = r_value;
    assign o_kind    = r_kind;
    assign o_channel = r_channel;
    assign o_error   = r_error;

endmodule

/* dv/tb_ascii_ppm_token_parser.sv */
// Self-checking testbench for ascii_ppm_token_parser: feeds characters of plain-text
// colour images and checks every emitted token against a cycle-free model of the parser.
// Depends on ppm_pkg and the parser RTL only.
module tb_ascii_ppm_token_parser;
    import ppm_pkg::*;

    localparam logic [1:0] KIND_HEIGHT = 2'd1;
    localparam logic [1:0] KIND_MAXVAL = 2'd2;
    localparam int unsigned HDR_CEILING = (HEADER_VALUE_BITS >= 16) ? 65535
                                        : (1 << HEADER_VALUE_BITS) - 1;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned CHARS_PER_PHASE = 420;
    localparam int unsigned MAX_REPORTS = 40;

    typedef struct {
        logic [7:0] ch;
        logic       eod;
        logic       typed;
        t_result    res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_char_in;
    logic        i_end_of_data;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_value;
    logic [1:0]  o_kind;
    logic [1:0]  o_channel;
    logic [1:0]  o_error;

    // parser model state
    t_phase      mdl_phase;
    t_lex        mdl_lex;
    logic [16:0] mdl_acc;
    logic [1:0]  mdl_hdr_idx;
    logic [1:0]  mdl_chan;

    t_result     pending_tokens[$];
    t_row        dir_rows[$];
    logic [7:0]  img_chars[$];
    t_result     head_token;

    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned chars_sent;
    int unsigned images_sent;
    int unsigned tokens_checked;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned phase_end;

    ascii_ppm_token_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_char_in     (i_char_in),
        .i_end_of_data (i_end_of_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_value       (o_value),
        .o_kind        (o_kind),
        .o_channel     (o_channel),
        .o_error       (o_error)
    );

    // clock, period 4
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // model: return to the state after reset
    function automatic void model_clear();
        mdl_phase   = PH_MAGIC;
        mdl_lex     = LX_SPACE;
        mdl_acc     = '0;
        mdl_hdr_idx = '0;
        mdl_chan    = CHAN_RED;
    endfunction

    // model: close the pending number as a header field or a sample
    function automatic t_result close_number();
        t_result r;
        r       = '0;
        r.valid = 1'b1;
        r.value = (mdl_acc > VALUE_MAX) ? 16'hFFFF : mdl_acc[15:0];
        if (mdl_phase == PH_HEADER) begin
            r.kind  = mdl_hdr_idx;
            r.error = (int'(mdl_acc) > HDR_CEILING) ? ERR_HEADER : ERR_NONE;
            if (mdl_hdr_idx == HDR_LAST) begin
                mdl_hdr_idx = '0;
                mdl_phase   = PH_BODY;
            end else begin
                mdl_hdr_idx = mdl_hdr_idx + 2'd1;
            end
        end else begin
            r.kind    = KIND_SAMPLE;
            r.channel = mdl_chan;
            // an oversized sample is dropped, the channel stays put
            if (mdl_acc > SAMPLE_MAX)
                r.error = ERR_SAMPLE;
            else
                mdl_chan = (mdl_chan == CHAN_BLUE) ? CHAN_RED : mdl_chan + 2'd1;
        end
        mdl_acc = '0;
        return r;
    endfunction

    // model: one character in, at most one token out
    function automatic t_result parse_char(logic [7:0] c, logic eod);
        t_result     r;
        logic        is_digit;
        int unsigned sum;
        r        = '0;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        case (mdl_phase)
            PH_MAGIC: begin
                if (c == CH_P) begin
                    mdl_phase = PH_FORMAT;
                end else begin
                    r.valid = 1'b1;
                    r.error = ERR_MAGIC;
                end
            end
            PH_FORMAT: begin
                if (c == CH_3) begin
                    mdl_phase = PH_HEADER;
                    mdl_lex   = LX_SPACE;
                    mdl_acc   = '0;
                end else begin
                    mdl_phase = PH_MAGIC;
                    r.valid   = 1'b1;
                    r.error   = ERR_MAGIC;
                end
            end
            default: begin
                if (mdl_lex == LX_COMMENT) begin
                    if (c == CH_LF)
                        mdl_lex = LX_SPACE;
                end else if (mdl_lex == LX_NUMBER) begin
                    if (is_digit) begin
                        sum     = int'(mdl_acc) * 10 + int'(c) - int'(CH_ZERO);
                        mdl_acc = (sum > int'(ACC_SAT)) ? ACC_SAT : sum[16:0];
                    end else begin
                        r       = close_number();
                        mdl_lex = (c == CH_HASH) ? LX_COMMENT : LX_SPACE;
                    end
                end else if (is_digit) begin
                    mdl_acc = 17'(c - CH_ZERO);
                    mdl_lex = LX_NUMBER;
                end else if (c == CH_HASH) begin
                    mdl_lex = LX_COMMENT;
                end
            end
        endcase
        // end of data flushes a pending number, then restarts the parser
        if (eod) begin
            if (!r.valid && mdl_lex == LX_NUMBER && mdl_phase >= PH_HEADER)
                r = close_number();
            model_clear();
        end
        return r;
    endfunction

    // hand one character to the block, then record the token it should cause
    task automatic feed_char(input logic [7:0] c, input logic eod,
                             input logic typed = 1'b0, input t_result fixed = '0);
        t_result tok;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_char_in     <= c;
        i_end_of_data <= eod;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        chars_sent++;
        tok = parse_char(c, eod);
        if (typed)
            tok = fixed;
        if (tok.valid)
            pending_tokens = {pending_tokens, tok};
    endtask

    // directed rows: untyped ones rely on the model
    function automatic void add_row(logic [7:0] c, logic eod = 1'b0);
        t_row row;
        row.ch    = c;
        row.eod   = eod;
        row.typed = 1'b0;
        row.res   = '0;
        dir_rows  = {dir_rows, row};
    endfunction

    function automatic void add_typed(logic [7:0] c, logic eod, logic has, logic [15:0] v,
                                      logic [1:0] k, logic [1:0] chan, logic [1:0] err);
        t_row row;
        row.ch    = c;
        row.eod   = eod;
        row.typed = 1'b1;
        row.res   = '{valid: has, value: v, kind: k, channel: chan, error: err};
        dir_rows  = {dir_rows, row};
    endfunction

    // random text that is neither a digit nor a comment start
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_HASH);
        return c;
    endfunction

    // one or more separators: blank, line feed, tab, odd byte or a comment line
    function automatic void add_sep();
        int unsigned sel;
        logic [7:0]  c;
        sel = $urandom_range(99);
        if (sel < 40) begin
            img_chars = {img_chars, 8'h20};
        end else if (sel < 58) begin
            img_chars = {img_chars, CH_LF};
        end else if (sel < 66) begin
            img_chars = {img_chars, 8'h09};
        end else if (sel < 84) begin
            img_chars = {img_chars, plain_char()};
        end else begin
            img_chars = {img_chars, CH_HASH};
            repeat ($urandom_range(6)) begin
                c = 8'($urandom_range(255));
                img_chars = {img_chars, ((c == CH_LF) ? 8'h20 : c)};
            end
            img_chars = {img_chars, CH_LF};
        end
        if ($urandom_range(9) == 0)
            add_sep();
    endfunction

    // one decimal number, mostly in sample range, now and then huge
    function automatic void add_number();
        int unsigned sel;
        int unsigned v;
        logic [7:0]  digits[$];
        sel = $urandom_range(99);
        if ($urandom_range(9) == 0)
            img_chars = {img_chars, CH_ZERO};
        if (sel >= 94) begin
            repeat ($urandom_range(12, 6))
                img_chars = {img_chars, 8'(CH_ZERO + $urandom_range(9))};
        end else begin
            if (sel < 76)
                v = $urandom_range(255);
            else if (sel < 88)
                v = $urandom_range(65535, 256);
            else
                v = $urandom_range(999999, 65536);
            do begin
                digits.push_front(8'(CH_ZERO + v % 10));
                v = v / 10;
            end while (v != 0);
            foreach (digits[i])
                img_chars = {img_chars, digits[i]};
        end
    endfunction

    // one image: mostly well formed, some with a broken magic, some pure noise
    function automatic void build_image();
        int unsigned sel;
        logic [7:0]  c;
        img_chars.delete();
        sel = $urandom_range(99);
        if (sel < 10) begin
            repeat ($urandom_range(20, 1))
                img_chars = {img_chars, 8'($urandom_range(255))};
            return;
        end
        if (sel < 14) begin
            do c = 8'($urandom_range(255)); while (c == CH_P);
            img_chars = {img_chars, c};
        end else begin
            img_chars = {img_chars, CH_P};
        end
        if (sel >= 14 && sel < 19) begin
            do c = 8'($urandom_range(255)); while (c == CH_3);
            img_chars = {img_chars, c};
        end else begin
            img_chars = {img_chars, CH_3};
        end
        if ($urandom_range(3) != 0)
            add_sep();
        repeat (3) begin
            add_number();
            add_sep();
        end
        repeat ($urandom_range(12)) begin
            add_number();
            add_sep();
        end
        // end on a bare number so it gets flushed
        if ($urandom_range(2) == 0)
            add_number();
        // cut short somewhere now and then
        if ($urandom_range(9) == 0)
            img_chars = img_chars[0 : $urandom_range(img_chars.size() - 1)];
    endfunction

    // receiver stall
    always @(posedge i_clk)
        i_stall <= ($urandom_range(99) < stall_pct);

    // compare each taken token with the oldest one predicted
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_tokens.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected token value %0d kind %0d channel %0d error %0d",
                             $time, o_value, o_kind, o_channel, o_error);
            end else begin
                head_token = pending_tokens.pop_front();
                tokens_checked++;
                if (o_value !== head_token.value || o_kind !== head_token.kind ||
                    o_channel !== head_token.channel || o_error !== head_token.error) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: token mismatch exp v%0d k%0d c%0d e%0d got v%0d k%0d c%0d e%0d",
                                 $time, head_token.value, head_token.kind, head_token.channel,
                                 head_token.error, o_value, o_kind, o_channel, o_error);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[ascii_ppm_token_parser] ERROR");
            $finish;
        end
    end

    initial begin
        idle_pct       = 0;
        stall_pct      = 0;
        chars_sent     = 0;
        images_sent    = 0;
        tokens_checked = 0;
        fail_count     = 0;
        cycle_count    = 0;
        model_clear();
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_char_in     <= 8'd0;
        i_end_of_data <= 1'b0;
        i_stall       <= 1'b0;

        // bad magic, comment, header overflow, extremes of the character range,
        // oversized sample, flush on end of data
        add_typed("A",    1'b0, 1'b1, 16'd0,     KIND_WIDTH,  CHAN_RED, ERR_MAGIC);
        add_typed(CH_P,   1'b0, 1'b0, 16'd0,     KIND_WIDTH,  CHAN_RED, ERR_NONE);
        add_typed("x",    1'b0, 1'b1, 16'd0,     KIND_WIDTH,  CHAN_RED, ERR_MAGIC);
        add_typed(CH_P,   1'b0, 1'b0, 16'd0,     KIND_WIDTH,  CHAN_RED, ERR_NONE);
        add_typed(CH_3,   1'b0, 1'b0, 16'd0,     KIND_WIDTH,  CHAN_RED, ERR_NONE);
        add_row(CH_HASH);
        add_row("9");
        add_row(CH_LF);
        add_row("7");
        add_row("0");
        add_row("0");
        add_row("0");
        add_row("0");
        add_typed(" ",    1'b0, 1'b1, 16'hFFFF,  KIND_WIDTH,  CHAN_RED, ERR_HEADER);
        add_row("0");
        add_typed(8'h00,  1'b0, 1'b1, 16'd0,     KIND_HEIGHT, CHAN_RED, ERR_NONE);
        add_row("2");
        add_row("5");
        add_row("5");
        add_typed(CH_HASH, 1'b0, 1'b1, 16'd255,  KIND_MAXVAL, CHAN_RED, ERR_NONE);
        add_row(CH_LF);
        add_row("2");
        add_row("5");
        add_row("6");
        add_typed(8'hFF,  1'b0, 1'b1, 16'd256,   KIND_SAMPLE, CHAN_RED, ERR_SAMPLE);
        add_row("0");
        add_typed("7",    1'b1, 1'b1, 16'd7,     KIND_SAMPLE, CHAN_RED, ERR_NONE);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, no idling
        foreach (dir_rows[i])
            feed_char(dir_rows[i].ch, dir_rows[i].eod, dir_rows[i].typed, dir_rows[i].res);

        // random images under four idling patterns
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 18; stall_pct = 18; end
            endcase
            phase_end = chars_sent + CHARS_PER_PHASE;
            while (chars_sent < phase_end) begin
                build_image();
                foreach (img_chars[i])
                    feed_char(img_chars[i], i == img_chars.size() - 1);
                images_sent++;
            end
            // hold off until every token so far is out
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (pending_tokens.size() != 0)
                @(posedge i_clk);
        end

        repeat (8) @(posedge i_clk);
        $display("ran %0d characters in %0d random images plus a directed stream", chars_sent,
                 images_sent);
        $display("checked %0d tokens under four sender and receiver idling patterns",
                 tokens_checked);
        if (fail_count == 0)
            $display("[ascii_ppm_token_parser] OK");
        else
            $display("[ascii_ppm_token_parser] ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/ppm_pkg.sv
rtl/ppm_step.sv
rtl/ascii_ppm_token_parser.sv
dv/tb_ascii_ppm_token_parser.sv
